>>> rtl/core/ccgp_pkg.sv
// Shared types, register codes and wheel constants for the crank/cam gap-pattern decoder.
// Used by every module under rtl/core; depends on nothing else.
package ccgp_pkg;

  localparam int WheelTeethDefault = 36;
  localparam int CfgIndexW = 3;
  localparam int CfgDataW = 20;

  typedef enum logic [2:0] {
    CFG_SEQUENTIAL_MODE    = 3'd0,
    CFG_WHEEL_ON_CAM       = 3'd1,
    CFG_CAM_PATTERN        = 3'd2,
    CFG_CRANK_FILTER       = 3'd3,
    CFG_CAM_FILTER_INITIAL = 3'd4
  } cfg_index_t;

  localparam logic [1:0] CAM_NONE   = 2'd0;
  localparam logic [1:0] CAM_SINGLE = 2'd1;
  localparam logic [1:0] CAM_532    = 2'd2;

  localparam logic CMD_CRANK = 1'b0;
  localparam logic CMD_CAM   = 1'b1;

  localparam int NumPatterns = 5;

  // The first entry that matches wins; entry k reports pattern number 5 - k.
  localparam logic [31:0] WHEEL_PATTERNS [0:NumPatterns-1] = '{
    32'hFDFD_FFBF,
    32'hDDFF_FB7F,
    32'hDBFF_F77F,
    32'hFDF7_FFBD,
    32'hFFF7_FFFD
  };

  typedef struct packed {
    logic        command;
    logic [31:0] timestamp;
  } event_t;

  typedef struct packed {
    logic [6:0]  tooth_number;
    logic        second_revolution;
    logic        synced;
    logic        half_synced;
    logic [2:0]  wheel_pattern;
    logic [7:0]  sync_losses;
    logic [15:0] start_revolutions;
    logic        accepted;
  } result_t;

  typedef struct packed {
    logic        sequential_mode;
    logic        wheel_on_cam;
    logic [1:0]  cam_pattern;
    logic [15:0] crank_filter_time;
  } cfg_t;

  typedef struct packed {
    logic [31:0] last_tooth_time;
    logic [31:0] prior_tooth_time;
    logic [31:0] last_crank_gap;
    logic [31:0] gap_history;
    logic [6:0]  tooth_count;
    logic        revolution_flag;
    logic        sync_flag;
    logic        half_sync_flag;
    logic [2:0]  pattern_id;
    logic [7:0]  loss_count;
    logic [15:0] revolution_count;
    logic [1:0]  crank_seen;
    logic [7:0]  cam_tooth_count;
    logic        cam_seen;
    logic [31:0] last_cam_time;
    logic [31:0] cam_target_gap;
    logic [30:0] cam_filter_time;
  } state_t;

  typedef struct packed {
    state_t state;
    logic   accepted;
  } update_t;

  // Adds teeth to the count and saturates at 127.
  function automatic logic [6:0] add_teeth(input logic [6:0] count, input logic [6:0] n);
    logic [7:0] sum;
    sum = {1'b0, count} + {1'b0, n};
    return sum[7] ? 7'h7F : sum[6:0];
  endfunction

endpackage

>>> rtl/core/crank_cam_gap_pattern_decoder.sv
// Crank/cam gap-pattern decoder top level: input register, decoder state, result register.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while no result stall holds the flow; the state update through
// the crank or cam logic sets that figure. An item is held in the input register while a result waits.
// Reset (rst, synchronous): clears all decoder state, configuration and both valid flags.
// Depends on ccgp_pkg, ccgp_crank and ccgp_cam.
module crank_cam_gap_pattern_decoder #(
  parameter int WHEEL_TEETH = ccgp_pkg::WheelTeethDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            event_valid,
  output logic                            event_stall,
  input  ccgp_pkg::event_t                event_item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output ccgp_pkg::result_t               result_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccgp_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [ccgp_pkg::CfgDataW-1:0]   cfg_data
);

  ccgp_pkg::cfg_t    cfg;
  ccgp_pkg::state_t  st;
  ccgp_pkg::state_t  st_next;
  ccgp_pkg::event_t  ev;
  logic              ev_valid;
  logic              advance;
  logic              take;
  ccgp_pkg::update_t crank_upd;
  ccgp_pkg::update_t cam_upd;
  ccgp_pkg::update_t upd;

  assign cfg_ready = 1'b1;
  assign advance = !result_valid || !result_stall;
  assign event_stall = ev_valid && !advance;
  assign take = event_valid && !event_stall;

  ccgp_crank #(.WHEEL_TEETH(WHEEL_TEETH)) u_crank (
    .cfg       (cfg),
    .cur       (st),
    .timestamp (ev.timestamp),
    .upd       (crank_upd)
  );

  ccgp_cam #(.WHEEL_TEETH(WHEEL_TEETH)) u_cam (
    .cfg       (cfg),
    .cur       (st),
    .timestamp (ev.timestamp),
    .upd       (cam_upd)
  );

  assign upd = (ev.command == ccgp_pkg::CMD_CAM) ? cam_upd : crank_upd;

  always_comb begin
    st_next = st;
    if (ev_valid && advance) begin
      st_next = upd.state;
    end
    if (cfg_valid && cfg_index == ccgp_pkg::CFG_CAM_FILTER_INITIAL) begin
      st_next.cam_filter_time = 31'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
      cfg <= '0;
      ev_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (take) begin
        ev_valid <= 1'b1;
      end else if (advance) begin
        ev_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= ev_valid;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          ccgp_pkg::CFG_SEQUENTIAL_MODE:    cfg.sequential_mode <= cfg_data[0];
          ccgp_pkg::CFG_WHEEL_ON_CAM:       cfg.wheel_on_cam <= cfg_data[0];
          ccgp_pkg::CFG_CAM_PATTERN:        cfg.cam_pattern <= cfg_data[1:0];
          ccgp_pkg::CFG_CRANK_FILTER:       cfg.crank_filter_time <= cfg_data[15:0];
          ccgp_pkg::CFG_CAM_FILTER_INITIAL: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev <= event_item;
    end
    if (ev_valid && advance) begin
      result_item.tooth_number <= upd.state.tooth_count;
      result_item.second_revolution <= upd.state.revolution_flag;
      result_item.synced <= upd.state.sync_flag;
      result_item.half_synced <= upd.state.half_sync_flag;
      result_item.wheel_pattern <= upd.state.pattern_id;
      result_item.sync_losses <= upd.state.loss_count;
      result_item.start_revolutions <= upd.state.revolution_count;
      result_item.accepted <= upd.accepted;
    end
  end

endmodule

>>> rtl/core/ccgp_crank.sv
// Next-state logic for one crank tooth: gap filter, history shift, pattern match and sync.
// Depends on ccgp_pkg.
module ccgp_crank #(
  parameter int WHEEL_TEETH = ccgp_pkg::WheelTeethDefault
) (
  input  ccgp_pkg::cfg_t    cfg,
  input  ccgp_pkg::state_t  cur,
  input  logic [31:0]       timestamp,
  output ccgp_pkg::update_t upd
);

  localparam logic [7:0] TeethW  = 8'(WHEEL_TEETH);
  localparam logic [7:0] TeethW1 = 8'(WHEEL_TEETH + 1);
  localparam logic [7:0] HalfW   = 8'(WHEEL_TEETH / 2);

  always_comb begin
    ccgp_pkg::state_t nxt;
    logic [31:0] gap;
    logic [31:0] delta;
    logic [32:0] target;
    logic        long_gap;
    logic [31:0] hist_new;
    logic [6:0]  count_new;
    logic        hit;
    logic [2:0]  hit_id;
    logic        acc;

    nxt = cur;
    gap = timestamp - cur.last_tooth_time;
    nxt.last_crank_gap = gap;
    acc = (gap >= {16'b0, cfg.crank_filter_time});

    delta = cur.last_tooth_time - cur.prior_tooth_time;
    target = {1'b0, delta} + {2'b0, delta[31:1]};
    long_gap = ({1'b0, gap} > target);
    hist_new = long_gap ? {cur.gap_history[29:0], 2'b01} : {cur.gap_history[30:0], 1'b1};
    count_new = ccgp_pkg::add_teeth(cur.tooth_count, long_gap ? 7'd2 : 7'd1);

    hit = 1'b0;
    hit_id = 3'd0;
    for (int k = 0; k < ccgp_pkg::NumPatterns; k++) begin
      if (!hit && hist_new == ccgp_pkg::WHEEL_PATTERNS[k]) begin
        hit = 1'b1;
        hit_id = 3'(ccgp_pkg::NumPatterns - k);
      end
    end

    if (acc) begin
      if (cur.crank_seen == 2'd2) begin
        nxt.sync_flag = 1'b1;
        nxt.gap_history = hist_new;
        nxt.tooth_count = count_new;
        if ({1'b0, count_new} >= TeethW) begin
          if (hit) begin
            nxt.pattern_id = hit_id;
            if ({1'b0, count_new} > HalfW) begin
              nxt.tooth_count = 7'd1;
              nxt.revolution_flag = ~cur.revolution_flag;
            end
            if (cfg.sequential_mode) begin
              if (cur.cam_tooth_count != 8'd0 || cfg.wheel_on_cam) begin
                nxt.sync_flag = 1'b1;
                nxt.half_sync_flag = 1'b0;
                if (cfg.cam_pattern == ccgp_pkg::CAM_SINGLE) begin
                  nxt.cam_tooth_count = 8'd0;
                end
              end else if (!nxt.sync_flag) begin
                nxt.half_sync_flag = 1'b1;
              end
            end else begin
              nxt.sync_flag = 1'b1;
              nxt.half_sync_flag = 1'b0;
            end
            if (nxt.sync_flag) begin
              nxt.revolution_count = cur.revolution_count + 16'd1;
            end else begin
              nxt.revolution_count = 16'd0;
            end
          end else if ({1'b0, count_new} > TeethW1) begin
            nxt.sync_flag = 1'b0;
            nxt.half_sync_flag = (cur.cam_tooth_count != 8'd0);
            nxt.loss_count = cur.loss_count + 8'd1;
          end
        end
      end else begin
        nxt.crank_seen = cur.crank_seen + 2'd1;
      end
      nxt.prior_tooth_time = cur.last_tooth_time;
      nxt.last_tooth_time = timestamp;
    end

    upd.state = nxt;
    upd.accepted = acc;
  end

endmodule

>>> rtl/core/ccgp_cam.sv
// Next-state logic for one cam tooth: cam gap filter, single-tooth and 5-3-2 phase tracking.
// Depends on ccgp_pkg.
module ccgp_cam #(
  parameter int WHEEL_TEETH = ccgp_pkg::WheelTeethDefault
) (
  input  ccgp_pkg::cfg_t    cfg,
  input  ccgp_pkg::state_t  cur,
  input  logic [31:0]       timestamp,
  output ccgp_pkg::update_t upd
);

  localparam logic [7:0] HalfW   = 8'(WHEEL_TEETH / 2);
  localparam logic [7:0] HalfW1  = 8'(WHEEL_TEETH / 2 + 1);
  localparam logic [7:0] HalfWm1 = 8'(WHEEL_TEETH / 2 - 1);

  always_comb begin
    ccgp_pkg::state_t nxt;
    logic [31:0] gap;
    logic [32:0] grown;
    logic [31:0] grown_sat;
    logic [7:0]  count_inc;
    logic [7:0]  tooth_sub;
    logic        acc;

    nxt = cur;
    if (!cur.cam_seen) begin
      nxt.cam_target_gap = {cur.last_crank_gap[30:0], 1'b0};
      nxt.last_cam_time = timestamp;
      nxt.cam_seen = 1'b1;
      gap = 32'd0;
    end else begin
      gap = timestamp - cur.last_cam_time;
    end
    acc = (gap >= {1'b0, cur.cam_filter_time});

    grown = {1'b0, gap} + {2'b0, gap[31:1]};
    grown_sat = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
    count_inc = (cur.cam_tooth_count != 8'hFF) ? cur.cam_tooth_count + 8'd1 : cur.cam_tooth_count;
    tooth_sub = {1'b0, cur.tooth_count} - HalfW;

    if (acc) begin
      nxt.cam_tooth_count = count_inc;
      nxt.last_cam_time = timestamp;
      case (cfg.cam_pattern)
        ccgp_pkg::CAM_SINGLE: begin
          nxt.revolution_flag = 1'b1;
          nxt.cam_filter_time = gap[31:1];
        end
        ccgp_pkg::CAM_532: begin
          if (gap < nxt.cam_target_gap) begin
            nxt.cam_filter_time = gap[31:1];
            nxt.cam_target_gap = grown_sat;
          end else begin
            if (count_inc == 8'd6) begin
              nxt.revolution_flag = 1'b0;
              if ({1'b0, cur.tooth_count} < HalfW1) begin
                nxt.tooth_count = ccgp_pkg::add_teeth(cur.tooth_count, HalfW[6:0]);
              end
            end else if (count_inc == 8'd4) begin
              nxt.revolution_flag = 1'b1;
              if ({1'b0, cur.tooth_count} > HalfWm1) begin
                nxt.tooth_count = tooth_sub[6:0];
              end
            end else if (count_inc == 8'd3) begin
              nxt.revolution_flag = 1'b1;
              if ({1'b0, cur.tooth_count} < HalfW1) begin
                nxt.tooth_count = ccgp_pkg::add_teeth(cur.tooth_count, HalfW[6:0]);
              end
            end
            nxt.cam_tooth_count = 8'd1;
          end
        end
        default: begin
        end
      endcase
    end

    upd.state = nxt;
    upd.accepted = acc;
  end

endmodule

>>> rtl/core/ccgp_checker.sv
// Port-level checks for the crank/cam gap-pattern decoder, bound to its top level.
// Depends on ccgp_pkg and crank_cam_gap_pattern_decoder.
module ccgp_checker (
  input logic              clk,
  input logic              rst,
  input logic              event_stall,
  input logic              result_valid,
  input logic              result_stall,
  input ccgp_pkg::result_t result_item
);

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // With no result waiting, the block always takes a new item.
  assert property (@(posedge clk) disable iff (rst) !result_valid |-> !event_stall)
    else $error("item stalled while no result waits");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // Only five wheel patterns exist.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.wheel_pattern <= 3'd5)
    else $error("wheel pattern out of range");

endmodule

bind crank_cam_gap_pattern_decoder ccgp_checker u_ccgp_checker (
  .clk          (clk),
  .rst          (rst),
  .event_stall  (event_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for crank_cam_gap_pattern_decoder: wheel-pattern tooth trains, cam sequences
// and noise run under random idling, and each result is checked against a model in this file.
// Depends on ccgp_pkg and the decoder RTL only.
module tb;
  import ccgp_pkg::*;

  localparam int Teeth = WheelTeethDefault;
  localparam int HalfTeeth = Teeth / 2;
  localparam logic [1:0] CAM_SPARE = 2'd3;
  localparam int unsigned CycleLimit = 1000000;
  localparam int PhaseItems = 235;
  localparam int NumPhases = 8;

  class tooth_sync_tracker;
    bit        seq_mode;
    bit        wheel_cam;
    bit [1:0]  cam_kind;
    bit [15:0] crank_floor;
    bit [31:0] last_tooth, prior_tooth, last_gap, history;
    bit [6:0]  teeth;
    bit        rev, sync, half;
    bit [2:0]  pattern;
    bit [7:0]  losses, cam_teeth;
    bit [15:0] revs;
    bit [1:0]  crank_depth;
    bit        cam_primed;
    bit [31:0] last_cam, cam_target, cam_floor;
    result_t   expected_status[$];
    int        mismatches;

    function void load_register(cfg_index_t idx, bit [19:0] value);
      case (idx)
        CFG_SEQUENTIAL_MODE: seq_mode = value[0];
        CFG_WHEEL_ON_CAM: wheel_cam = value[0];
        CFG_CAM_PATTERN: cam_kind = value[1:0];
        CFG_CRANK_FILTER: crank_floor = value[15:0];
        CFG_CAM_FILTER_INITIAL: cam_floor = {12'd0, value};
        default: ;
      endcase
    endfunction

    function void add_to_count(int n);
      int total;
      total = teeth + n;
      teeth = (total > 127) ? 7'd127 : total[6:0];
    endfunction

    function void lock_revolution();
      if (teeth > HalfTeeth) begin
        teeth = 7'd1;
        rev = !rev;
      end
      if (seq_mode) begin
        if (cam_teeth > 0 || wheel_cam) begin
          sync = 1'b1;
          half = 1'b0;
          if (cam_kind == CAM_SINGLE) cam_teeth = 8'd0;
        end else if (!sync) begin
          half = 1'b1;
        end
      end else begin
        sync = 1'b1;
        half = 1'b0;
      end
      revs = sync ? revs + 16'd1 : 16'd0;
    endfunction

    function bit crank_tooth(bit [31:0] stamp);
      bit [31:0] gap;
      bit [33:0] span, limit;
      int        hit;
      gap = stamp - last_tooth;
      last_gap = gap;
      if (gap < crank_floor) return 1'b0;
      if (crank_depth >= 2) begin
        span = {2'b00, last_tooth - prior_tooth};
        limit = span + (span >> 1);
        sync = 1'b1;
        if ({2'b00, gap} > limit) begin
          history = (history << 2) + 32'd1;
          add_to_count(2);
        end else begin
          history = (history << 1) + 32'd1;
          add_to_count(1);
        end
        if (teeth >= Teeth) begin
          hit = -1;
          for (int k = 0; k < NumPatterns; k++) begin
            if (hit < 0 && history == WHEEL_PATTERNS[k]) hit = k;
          end
          if (hit >= 0) begin
            pattern = 3'(NumPatterns - hit);
            lock_revolution();
          end else if (teeth > Teeth + 1) begin
            sync = 1'b0;
            half = (cam_teeth > 0);
            losses = losses + 8'd1;
          end
        end
      end else begin
        crank_depth = crank_depth + 2'd1;
      end
      prior_tooth = last_tooth;
      last_tooth = stamp;
      return 1'b1;
    endfunction

    function bit cam_tooth(bit [31:0] stamp);
      bit [31:0] gap;
      bit [32:0] grown;
      gap = stamp - last_cam;
      if (!cam_primed) begin
        cam_target = last_gap << 1;
        gap = '0;
        last_cam = stamp;
        cam_primed = 1'b1;
      end
      if (gap < cam_floor) return 1'b0;
      if (cam_teeth < 8'd255) cam_teeth = cam_teeth + 8'd1;
      last_cam = stamp;
      if (cam_kind == CAM_SINGLE) begin
        rev = 1'b1;
        cam_floor = gap >> 1;
      end else if (cam_kind == CAM_532) begin
        if (gap < cam_target) begin
          grown = {1'b0, gap} + {2'b00, gap[31:1]};
          cam_floor = gap >> 1;
          cam_target = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
        end else begin
          if (cam_teeth == 8'd6) begin
            rev = 1'b0;
            if (teeth < HalfTeeth + 1) add_to_count(HalfTeeth);
          end else if (cam_teeth == 8'd4) begin
            rev = 1'b1;
            if (teeth > HalfTeeth - 1) teeth = teeth - 7'(HalfTeeth);
          end else if (cam_teeth == 8'd3) begin
            rev = 1'b1;
            if (teeth < HalfTeeth + 1) add_to_count(HalfTeeth);
          end
          cam_teeth = 8'd1;
        end
      end
      return 1'b1;
    endfunction

    function void note_event(event_t item);
      result_t status;
      bit      ok;
      ok = (item.command == CMD_CAM) ? cam_tooth(item.timestamp) : crank_tooth(item.timestamp);
      status.tooth_number = teeth;
      status.second_revolution = rev;
      status.synced = sync;
      status.half_synced = half;
      status.wheel_pattern = pattern;
      status.sync_losses = losses;
      status.start_revolutions = revs;
      status.accepted = ok;
      expected_status.push_back(status);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 100) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_status.size() == 0) begin
        report_mismatch("result arrived with no item outstanding");
        return;
      end
      want = expected_status.pop_front();
      if (got.tooth_number !== want.tooth_number)
        report_mismatch($sformatf("tooth_number %0d, expected %0d",
                                  got.tooth_number, want.tooth_number));
      if (got.second_revolution !== want.second_revolution)
        report_mismatch($sformatf("second_revolution %b, expected %b",
                                  got.second_revolution, want.second_revolution));
      if (got.synced !== want.synced)
        report_mismatch($sformatf("synced %b, expected %b", got.synced, want.synced));
      if (got.half_synced !== want.half_synced)
        report_mismatch($sformatf("half_synced %b, expected %b",
                                  got.half_synced, want.half_synced));
      if (got.wheel_pattern !== want.wheel_pattern)
        report_mismatch($sformatf("wheel_pattern %0d, expected %0d",
                                  got.wheel_pattern, want.wheel_pattern));
      if (got.sync_losses !== want.sync_losses)
        report_mismatch($sformatf("sync_losses %0d, expected %0d",
                                  got.sync_losses, want.sync_losses));
      if (got.start_revolutions !== want.start_revolutions)
        report_mismatch($sformatf("start_revolutions %0d, expected %0d",
                                  got.start_revolutions, want.start_revolutions));
      if (got.accepted !== want.accepted)
        report_mismatch($sformatf("accepted %b, expected %b", got.accepted, want.accepted));
    endtask

    task close_out();
      if (expected_status.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_status.size()));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                event_valid = 1'b0;
  logic                event_stall;
  event_t              event_item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  tooth_sync_tracker   board;
  int unsigned         cycles_run = 0;
  int                  items_sent = 0;
  bit                  send_calm = 1'b0;
  bit                  take_calm = 1'b0;
  logic [15:0]         crank_floor_now = '0;
  int                  period = 100;
  int                  cam_pct = 20;
  int                  cam_left = 0;
  int                  cam_group = 0;
  logic [31:0]         crank_now = '0;
  logic [31:0]         cam_now = '0;
  int                  cam_group_sizes[3] = '{5, 3, 2};

  crank_cam_gap_pattern_decoder u_dut (
    .clk(clk),
    .rst(rst),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_item(event_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pause_draw(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 18);
  endfunction

  function automatic int jitter(int base);
    int spread;
    spread = $urandom_range(0, base / 8);
    return base + spread - base / 16;
  endfunction

  task automatic send_event(input logic cmd, input logic [31:0] stamp);
    event_t item;
    int     hold;
    item.command = cmd;
    item.timestamp = stamp;
    hold = pause_draw(send_calm);
    if (hold > 0) begin
      event_valid <= 1'b0;
      repeat (hold) @(negedge clk);
    end
    event_valid <= 1'b1;
    event_item <= item;
    do @(posedge clk); while (event_stall);
    board.note_event(item);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [19:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    board.load_register(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_settings(input bit seq, input bit cam_wheel, input logic [1:0] cam,
                                input logic [15:0] crank_f, input logic [19:0] cam_init);
    event_valid <= 1'b0;
    while (board.expected_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_register(CFG_SEQUENTIAL_MODE, {19'd0, seq});
    write_register(CFG_WHEEL_ON_CAM, {19'd0, cam_wheel});
    write_register(CFG_CAM_PATTERN, {18'd0, cam});
    write_register(CFG_CRANK_FILTER, {4'd0, crank_f});
    write_register(CFG_CAM_FILTER_INITIAL, cam_init);
    cfg_valid <= 1'b0;
    crank_floor_now = crank_f;
    period = 2 * crank_f + $urandom_range(40, 4000);
    cam_pct = (cam == CAM_NONE) ? 10 : 25;
  endtask

  task automatic send_cam_tooth();
    if (cam_left == 0) begin
      cam_group = (cam_group + 1) % 3;
      cam_left = cam_group_sizes[cam_group] - 1;
      cam_now = cam_now + jitter(3 * period);
    end else begin
      cam_left--;
      cam_now = cam_now + jitter(period);
    end
    send_event(CMD_CAM, cam_now);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_event(1'($urandom_range(0, 1)), $urandom());
      1: send_event(CMD_CRANK, crank_now + $urandom_range(0, crank_floor_now));
      default: send_event(CMD_CAM, cam_now + $urandom_range(0, 50));
    endcase
  endtask

  task automatic crank_token(input bit is_long);
    crank_now = crank_now + jitter(is_long ? 2 * period : period);
    send_event(CMD_CRANK, crank_now);
    if ($urandom_range(0, 99) < 4) send_noise();
    if ($urandom_range(0, 99) < cam_pct) send_cam_tooth();
  endtask

  // One pass of a wheel pattern after a few plain teeth; now and then one gap is distorted.
  task automatic run_revolution();
    logic [31:0] shape;
    int          bit_at;
    int          token;
    int          flip_at;
    bit          is_long;
    shape = WHEEL_PATTERNS[$urandom_range(0, NumPatterns - 1)];
    flip_at = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 29) : -1;
    repeat ($urandom_range(3, 6)) crank_token(1'b0);
    bit_at = 31;
    token = 0;
    while (bit_at >= 0) begin
      is_long = (shape[bit_at] == 1'b0) && (bit_at > 0);
      bit_at -= is_long ? 2 : 1;
      if (token == flip_at) is_long = !is_long;
      crank_token(is_long);
      token++;
    end
  endtask

  initial begin : stimulus
    logic [31:0] base;
    int          phase_start;
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    apply_settings(1'b0, 1'b0, CAM_532, 16'd0, 20'd1);
    send_event(CMD_CRANK, 32'h0000_0000);
    send_event(CMD_CRANK, 32'hFFFF_FFFF);
    send_event(CMD_CRANK, 32'h7FFF_FFFE);
    send_event(CMD_CAM, 32'h0000_0000);
    send_event(CMD_CAM, 32'hC000_0000);
    send_event(CMD_CAM, 32'hC000_0001);
    send_event(CMD_CAM, 32'h4000_0000);
    send_event(CMD_CAM, 32'hFFFF_FFFF);
    send_event(CMD_CRANK, 32'h7FFF_FFFE + 32'd100);
    send_event(CMD_CRANK, 32'h7FFF_FFFE + 32'd400);

    base = 32'h7FFF_FFFE + 32'd400;
    apply_settings(1'b1, 1'b1, CAM_SINGLE, 16'd65535, 20'd1000000);
    send_event(CMD_CRANK, base + 32'd100);
    send_event(CMD_CRANK, base + 32'd65535);
    send_event(CMD_CRANK, base + 32'd131069);
    send_event(CMD_CAM, 32'h000F_423E);
    send_event(CMD_CAM, 32'h000F_423F);
    send_event(CMD_CRANK, base + 32'd196605);
    send_event(CMD_CRANK, 32'hFFFF_FFFF);
    send_event(CMD_CRANK, 32'h0000_0000);
    send_event(CMD_CAM, 32'h0000_0000);

    crank_now = $urandom();
    cam_now = $urandom();
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: apply_settings(1'b0, 1'b0, CAM_NONE, 16'd0, 20'd0);
        1: apply_settings(1'b1, 1'b0, CAM_SINGLE, 16'd65535, 20'd1000000);
        2: apply_settings(1'b1, 1'b0, CAM_532, 16'($urandom_range(0, 500)), 20'd0);
        3: apply_settings(1'b1, 1'b1, CAM_SPARE, 16'($urandom_range(0, 300)),
                          20'($urandom_range(0, 200)));
        NumPhases - 1: apply_settings(1'b0, 1'b1, CAM_532, 16'd1, 20'd0);
        default: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                2'($urandom_range(0, 3)),
                                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                             : 16'($urandom_range(0, 300)),
                                ($urandom_range(0, 7) == 0) ? 20'($urandom_range(0, 1000000))
                                                             : 20'($urandom_range(0, 200)));
      endcase
      // Cam teeth dominate the first phase so that the cam counter climbs, since no cam pattern resets it there.
      if (p == 0) cam_pct = 90;
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        send_calm = ($urandom_range(0, 4) == 0);
        take_calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 99) < 85) begin
          run_revolution();
        end else begin
          repeat ($urandom_range(1, 5)) send_noise();
        end
      end
    end

    event_valid <= 1'b0;
    while (board.expected_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    board.close_out();
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : result_sink
    int hold;
    while (rst) @(negedge clk);
    forever begin
      hold = pause_draw(take_calm);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      board.check_result(result_item);
      @(negedge clk);
    end
  end

endmodule
